@@ hw/rtl/swhs_pkg.sv @@
// shared types and constants for the single-wire humidity sensor decoder
// no dependencies
package swhs_pkg;

  // free-running capture timer width; widths wrap at this many bits
  localparam int TIMER_WIDTH = 16;
  localparam int CAPTURE_W   = 16;
  // effective measured width: timer bits that survive the capture field
  localparam int TW          = (TIMER_WIDTH < CAPTURE_W) ? TIMER_WIDTH : CAPTURE_W;

  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int FRAME_W    = 40;
  localparam int PCOUNT_W   = 6;

  localparam logic [PCOUNT_W-1:0] DATA_BITS = 6'd40;
  localparam logic [CFG_W-1:0] THRESH_RESET = 16'd83;
  localparam logic [CFG_W-1:0] LEAD_RESET   = 16'd5000;
  localparam logic [6:0] MAG_MASK = 7'h7f;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_THRESHOLD = 1'b0,
    CFG_LEAD_IN_LIMIT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                 start_read;
    logic                 pin_level;
    logic [CAPTURE_W-1:0] capture_time;
  } in_item_t;

  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } frame_evt_t;

endpackage

@@ hw/rtl/single_wire_humidity_sensor_decoder_unit.sv @@
// Single-wire humidity sensor pulse-width decoder. Each input transaction is one
// capture event (start flag, line level, timer value); the block takes one per
// clock; the transaction that completes the fortieth data bit passes the input
// register and then the result register. The rate is set by the update of the
// read state (rise time, pulse counter, 40-bit shift register) between the input
// register and the result register; while a result waits under stall the input
// side stalls too. Configuration writes take effect on the next accepted edge.
// depends on swhs_pkg, swhs_frame, swhs_result
module single_wire_humidity_sensor_decoder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_start_read,
  input  logic                           in_pin_level,
  input  logic [15:0]                    in_capture_time,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_checksum_ok,
  output logic [15:0]                    out_humidity_raw,
  output logic signed [15:0]             out_temperature,
  input  logic                           cfg_wr_en,
  input  logic [swhs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swhs_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [swhs_pkg::CFG_W-1:0] bit_threshold_r;
  logic [swhs_pkg::CFG_W-1:0] lead_in_limit_r;

  logic                 in_valid_r;
  swhs_pkg::in_item_t   in_item_r;
  logic                 fire;
  logic                 out_free;
  swhs_pkg::frame_evt_t evt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_threshold_r <= swhs_pkg::THRESH_RESET;
      lead_in_limit_r <= swhs_pkg::LEAD_RESET;
    end else if (cfg_wr_en) begin
      unique case (swhs_pkg::cfg_idx_t'(cfg_index))
        swhs_pkg::CFG_BIT_THRESHOLD: bit_threshold_r <= cfg_wdata;
        swhs_pkg::CFG_LEAD_IN_LIMIT: lead_in_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign fire     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r.start_read   <= in_start_read;
      in_item_r.pin_level    <= in_pin_level;
      in_item_r.capture_time <= in_capture_time;
    end
  end

  swhs_frame u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .item          (in_item_r),
    .bit_threshold (bit_threshold_r),
    .lead_in_limit (lead_in_limit_r),
    .evt           (evt)
  );

  swhs_result u_result (
    .clk              (clk),
    .rst_n            (rst_n),
    .evt              (evt),
    .out_stall        (out_stall),
    .out_free         (out_free),
    .out_valid        (out_valid),
    .out_checksum_ok  (out_checksum_ok),
    .out_humidity_raw (out_humidity_raw),
    .out_temperature  (out_temperature)
  );

endmodule

@@ hw/rtl/swhs_frame.sv @@
// pulse measurement, lead-in skip and bit packing for one read
// depends on swhs_pkg
module swhs_frame (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  swhs_pkg::in_item_t        item,
  input  logic [swhs_pkg::CFG_W-1:0] bit_threshold,
  input  logic [swhs_pkg::CFG_W-1:0] lead_in_limit,
  output swhs_pkg::frame_evt_t      evt
);

  logic [swhs_pkg::TW-1:0]       rise_time_r, rise_time_nxt;
  logic [swhs_pkg::PCOUNT_W-1:0] pulse_count_r, pulse_count_nxt;
  logic [1:0]                    skip_count_r, skip_count_nxt;
  logic [swhs_pkg::FRAME_W-1:0]  frame_bits_r, frame_bits_nxt;
  logic                          frame_done_r, frame_done_nxt;

  logic [swhs_pkg::TW-1:0]       t_m;
  logic [swhs_pkg::TW-1:0]       width;
  logic [swhs_pkg::CFG_W-1:0]    width_ext;
  logic [swhs_pkg::PCOUNT_W-1:0] pc_inc;
  logic                          emit;

  assign t_m       = item.capture_time[swhs_pkg::TW-1:0];
  assign width     = t_m - rise_time_r;
  assign width_ext = swhs_pkg::CFG_W'(width);

  always_comb begin
    rise_time_nxt   = rise_time_r;
    pulse_count_nxt = pulse_count_r;
    skip_count_nxt  = skip_count_r;
    frame_bits_nxt  = frame_bits_r;
    frame_done_nxt  = frame_done_r;
    emit            = 1'b0;
    pc_inc          = '0;
    // start clears the read but keeps the last rise
    if (item.start_read) begin
      pulse_count_nxt = '0;
      skip_count_nxt  = 2'd1;
      frame_bits_nxt  = '0;
      frame_done_nxt  = 1'b0;
    end
    if (item.pin_level) begin
      rise_time_nxt = t_m;
    end else if (!frame_done_nxt) begin
      if (pulse_count_nxt == '0) begin
        skip_count_nxt  = (width_ext > lead_in_limit) ? 2'd2 : 2'd1;
        pulse_count_nxt = swhs_pkg::PCOUNT_W'(1);
      end else if (pulse_count_nxt < swhs_pkg::PCOUNT_W'(skip_count_nxt)) begin
        pulse_count_nxt = pulse_count_nxt + 1'b1;
      end else begin
        frame_bits_nxt  = {frame_bits_nxt[swhs_pkg::FRAME_W-2:0],
                           (width_ext >= bit_threshold)};
        pc_inc          = pulse_count_nxt + 1'b1;
        pulse_count_nxt = pc_inc;
        if ((pc_inc - swhs_pkg::PCOUNT_W'(skip_count_nxt)) >= swhs_pkg::DATA_BITS) begin
          frame_done_nxt = 1'b1;
          emit           = 1'b1;
        end
      end
    end
  end

  assign evt.valid = fire && emit;
  assign evt.frame = frame_bits_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_time_r   <= '0;
      pulse_count_r <= '0;
      skip_count_r  <= 2'd1;
      frame_bits_r  <= '0;
      frame_done_r  <= 1'b0;
    end else if (fire) begin
      rise_time_r   <= rise_time_nxt;
      pulse_count_r <= pulse_count_nxt;
      skip_count_r  <= skip_count_nxt;
      frame_bits_r  <= frame_bits_nxt;
      frame_done_r  <= frame_done_nxt;
    end
  end

endmodule

@@ hw/rtl/swhs_result.sv @@
// unpacks a finished frame, checks the byte sum and holds the result register
// depends on swhs_pkg
module swhs_result (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swhs_pkg::frame_evt_t evt,
  input  logic                 out_stall,
  output logic                 out_free,
  output logic                 out_valid,
  output logic                 out_checksum_ok,
  output logic [15:0]          out_humidity_raw,
  output logic signed [15:0]   out_temperature
);

  logic [7:0]  b0, b1, b2, b3, b4;
  logic [7:0]  sum;
  logic [14:0] mag;
  logic [15:0] temp;

  logic        out_valid_r, out_valid_nxt;
  logic        checksum_ok_r;
  logic [15:0] humidity_r;
  logic [15:0] temperature_r;

  assign b0  = evt.frame[39:32];
  assign b1  = evt.frame[31:24];
  assign b2  = evt.frame[23:16];
  assign b3  = evt.frame[15:8];
  assign b4  = evt.frame[7:0];
  assign sum = b0 + b1 + b2 + b3;
  assign mag = {b2[6:0] & swhs_pkg::MAG_MASK, b3};
  // sign-magnitude to two's complement, negative zero folds to zero
  assign temp = b2[7] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};

  assign out_free      = !out_valid_r || !out_stall;
  assign out_valid_nxt = evt.valid ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid) begin
      checksum_ok_r <= (b4 == sum);
      humidity_r    <= {b0, b1};
      temperature_r <= temp;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_checksum_ok  = checksum_ok_r;
  assign out_humidity_raw = humidity_r;
  assign out_temperature  = $signed(temperature_r);

endmodule

@@ verif/swhs_reading_checker.sv @@
`timescale 1ns / 1ps
// checker for single_wire_humidity_sensor_decoder_unit: decodes accepted capture transactions
// with its own pulse-width decoder and compares every result transaction in order
// depends on swhs_pkg
module swhs_reading_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_start_read,
  input  logic                           in_pin_level,
  input  logic [swhs_pkg::CAPTURE_W-1:0] in_capture_time,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_checksum_ok,
  input  logic [15:0]                    out_humidity_raw,
  input  logic signed [15:0]             out_temperature,
  input  logic                           cfg_wr_en,
  input  swhs_pkg::cfg_idx_t             cfg_index,
  input  logic [swhs_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             readings_due,
  output int                             mismatches
);

  typedef struct packed {
    logic               checksum_ok;
    logic [15:0]        humidity_raw;
    logic signed [15:0] temperature;
  } reading_t;

  reading_t readings_q[$];

  logic [swhs_pkg::CFG_W-1:0]    bit_thr;
  logic [swhs_pkg::CFG_W-1:0]    lead_limit;
  logic [swhs_pkg::TW-1:0]       last_rise;
  logic [swhs_pkg::PCOUNT_W-1:0] pulses;
  logic [1:0]                    lead_pulses;
  logic [swhs_pkg::FRAME_W-1:0]  shift_bits;
  logic                          frame_closed;
  int                            errs = 0;

  task automatic clear_frame();
    pulses       = '0;
    lead_pulses  = 2'd1;
    shift_bits   = '0;
    frame_closed = 1'b0;
  endtask

  task automatic decode_edge(input logic start, input logic level,
                             input logic [swhs_pkg::CAPTURE_W-1:0] stamp);
    logic [swhs_pkg::TW-1:0] width;
    logic [7:0]              b0, b1, b2, b3, b4;
    logic [15:0]             mag;
    reading_t                r;
    if (start) clear_frame();
    if (level) begin
      last_rise = stamp[swhs_pkg::TW-1:0];
    end else begin
      // width wraps at the timer width
      width = stamp[swhs_pkg::TW-1:0] - last_rise;
      if (frame_closed) begin
        // pulses after a full frame wait for the next start
      end else if (pulses == '0) begin
        lead_pulses = (width > lead_limit) ? 2'd2 : 2'd1;
        pulses      = swhs_pkg::PCOUNT_W'(1);
      end else if (pulses < swhs_pkg::PCOUNT_W'(lead_pulses)) begin
        pulses = pulses + 1'b1;
      end else begin
        shift_bits = {shift_bits[swhs_pkg::FRAME_W-2:0], (width >= bit_thr)};
        pulses     = pulses + 1'b1;
        if (pulses - swhs_pkg::PCOUNT_W'(lead_pulses) >= swhs_pkg::DATA_BITS) begin
          {b0, b1, b2, b3, b4} = shift_bits;
          // sign-magnitude to two's complement, negative zero folds to zero
          mag             = {1'b0, b2[6:0] & swhs_pkg::MAG_MASK, b3};
          r.checksum_ok   = (b4 == 8'(b0 + b1 + b2 + b3));
          r.humidity_raw  = {b0, b1};
          r.temperature   = b2[7] ? -mag : mag;
          frame_closed    = 1'b1;
          readings_q.push_back(r);
        end
      end
    end
  endtask

  task automatic check_reading();
    reading_t exp_r;
    if (readings_q.size() == 0) begin
      errs++;
      if (errs <= 10)
        $display("%0t: unexpected reading ok=%0b hum=%0d temp=%0d", $realtime,
                 out_checksum_ok, out_humidity_raw, out_temperature);
    end else begin
      exp_r = readings_q.pop_front();
      if (exp_r.checksum_ok !== out_checksum_ok || exp_r.humidity_raw !== out_humidity_raw ||
          exp_r.temperature !== out_temperature) begin
        errs++;
        if (errs <= 10)
          $display("%0t: expected ok=%0b hum=%0d temp=%0d got ok=%0b hum=%0d temp=%0d",
                   $realtime, exp_r.checksum_ok, exp_r.humidity_raw, exp_r.temperature,
                   out_checksum_ok, out_humidity_raw, out_temperature);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      bit_thr    = swhs_pkg::THRESH_RESET;
      lead_limit = swhs_pkg::LEAD_RESET;
      last_rise  = '0;
      clear_frame();
      readings_q.delete();
    end else begin
      // compare first so a transaction can never match its own prediction
      if (out_valid && !out_stall) check_reading();
      if (cfg_wr_en) begin
        case (cfg_index)
          swhs_pkg::CFG_BIT_THRESHOLD: bit_thr    = cfg_wdata;
          swhs_pkg::CFG_LEAD_IN_LIMIT: lead_limit = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_edge(in_start_read, in_pin_level, in_capture_time);
    end
    readings_due <= readings_q.size();
    mismatches   <= errs;
  end

endmodule

@@ verif/single_wire_humidity_sensor_decoder_unit_tb.sv @@
`timescale 1ns / 1ps
// top of the testbench for single_wire_humidity_sensor_decoder_unit: drives sensor edge
// transactions and register writes, stalls the result side and gives the verdict
// depends on swhs_pkg, swhs_reading_checker and the decoder rtl
module single_wire_humidity_sensor_decoder_unit_tb;

  localparam int IDLE_LIMIT         = 2000;
  localparam int SETTLE_CYCLES      = 8;
  localparam int ITEM_TARGET        = 1900;
  localparam int PHASES             = 6;
  localparam int READINGS_PER_PHASE = 2;
  localparam logic [7:0] SIGN_BIT   = 8'h80;

  typedef enum int {
    FRAME_NEG_ZERO,
    FRAME_ALL_ONES,
    FRAME_ALL_ZERO,
    FRAME_BAD_SUM,
    FRAME_RANDOM
  } frame_kind_t;

  logic                           clk             = 1'b0;
  logic                           rst_n           = 1'b0;
  logic                           in_valid        = 1'b0;
  logic                           in_start_read   = 1'b0;
  logic                           in_pin_level    = 1'b0;
  logic [swhs_pkg::CAPTURE_W-1:0] in_capture_time = '0;
  logic                           out_stall       = 1'b0;
  logic                           cfg_wr_en       = 1'b0;
  swhs_pkg::cfg_idx_t             cfg_index       = swhs_pkg::CFG_BIT_THRESHOLD;
  logic [swhs_pkg::CFG_W-1:0]     cfg_wdata       = '0;

  logic               in_stall;
  logic               out_valid;
  logic               out_checksum_ok;
  logic [15:0]        out_humidity_raw;
  logic signed [15:0] out_temperature;

  int readings_due;
  int mismatches;

  // register values currently written, used to shape pulse widths
  logic [swhs_pkg::CFG_W-1:0] thr  = swhs_pkg::THRESH_RESET;
  logic [swhs_pkg::CFG_W-1:0] lead = swhs_pkg::LEAD_RESET;

  bit calm          = 1'b0;
  int stall_left    = 0;
  int idle_cycles   = 0;
  int readings_seen = 0;
  int edges_sent    = 0;
  int frames_sent   = 0;

  always #2 clk = ~clk;

  single_wire_humidity_sensor_decoder_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_read    (in_start_read),
    .in_pin_level     (in_pin_level),
    .in_capture_time  (in_capture_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_checksum_ok  (out_checksum_ok),
    .out_humidity_raw (out_humidity_raw),
    .out_temperature  (out_temperature),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  swhs_reading_checker reading_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_read    (in_start_read),
    .in_pin_level     (in_pin_level),
    .in_capture_time  (in_capture_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_checksum_ok  (out_checksum_ok),
    .out_humidity_raw (out_humidity_raw),
    .out_temperature  (out_temperature),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .readings_due     (readings_due),
    .mismatches       (mismatches)
  );

  // mostly short gaps, a few long ones, none at all in calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // result-side stalls, result count and watchdog
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 99) < 20) stall_left <= pick_gap();
    end
    if (out_valid && !out_stall) readings_seen <= readings_seen + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("single_wire_humidity_sensor_decoder_unit verification failed");
      $finish;
    end
  end

  task automatic drive_edge(input logic start, input logic level,
                            input logic [swhs_pkg::CAPTURE_W-1:0] stamp, input bit counted);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_start_read   <= start;
    in_pin_level    <= level;
    in_capture_time <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (counted) edges_sent++;
  endtask

  function automatic logic [swhs_pkg::FRAME_W-1:0] make_frame(input frame_kind_t kind);
    logic [7:0] h1, h0, t1, t0, sum;
    h1 = 8'($urandom);
    h0 = 8'($urandom);
    t1 = 8'($urandom);
    t0 = 8'($urandom);
    case (kind)
      FRAME_NEG_ZERO: begin
        t1 = SIGN_BIT;
        t0 = '0;
      end
      FRAME_ALL_ONES: {h1, h0, t1, t0} = '1;
      FRAME_ALL_ZERO: {h1, h0, t1, t0} = '0;
      default: ;
    endcase
    sum = h1 + h0 + t1 + t0;
    if (kind == FRAME_BAD_SUM || (kind == FRAME_RANDOM && $urandom_range(0, 3) == 0))
      sum = sum ^ 8'($urandom_range(1, 255));
    return {h1, h0, t1, t0, sum};
  endfunction

  // one read: start rise, lead pulse(s), data pulses, then ignored trailing pulses
  task automatic send_frame(input logic [swhs_pkg::FRAME_W-1:0] payload, input int nbits,
                            input bit glitchy, input int extras);
    logic [swhs_pkg::CAPTURE_W-1:0] stamp;
    logic [swhs_pkg::CAPTURE_W-1:0] width;
    bit                             two_lead;
    stamp = 16'($urandom);
    drive_edge(1'b1, 1'b1, stamp, 1'b1);
    two_lead = (lead != '1) && ($urandom_range(0, 1) == 1);
    width = two_lead ? 16'($urandom_range(lead + 1, 65535)) : 16'($urandom_range(0, lead));
    stamp += width;
    drive_edge(1'b0, 1'b0, stamp, 1'b1);
    if (two_lead) begin
      stamp += 16'($urandom_range(1, 100));
      drive_edge(1'b0, 1'b1, stamp, 1'b1);
      stamp += 16'($urandom_range(0, 200));
      drive_edge(1'b0, 1'b0, stamp, 1'b1);
    end
    for (int i = 0; i < nbits; i++) begin
      stamp += 16'($urandom_range(1, 80));
      drive_edge(1'b0, 1'b1, stamp, 1'b1);
      if (glitchy && $urandom_range(0, 7) == 0) begin
        stamp += 16'($urandom_range(0, 40));
        drive_edge(1'b0, 1'b1, stamp, 1'b1);
      end
      // land on the threshold now and then
      if (payload[swhs_pkg::FRAME_W-1-i])
        width = ($urandom_range(0, 3) == 0) ? thr : 16'($urandom_range(thr, 65535));
      else if (thr == '0)
        width = 16'($urandom);
      else
        width = ($urandom_range(0, 3) == 0) ? thr - 1'b1 : 16'($urandom_range(0, thr - 1));
      stamp += width;
      drive_edge(1'b0, 1'b0, stamp, 1'b1);
      if (glitchy && $urandom_range(0, 7) == 0) begin
        stamp += 16'($urandom_range(0, 400));
        drive_edge(1'b0, 1'b0, stamp, 1'b1);
      end
    end
    for (int k = 0; k < extras; k++) begin
      stamp += 16'($urandom_range(1, 80));
      drive_edge(1'b0, 1'b1, stamp, 1'b0);
      stamp += 16'($urandom_range(0, 200));
      drive_edge(1'b0, 1'b0, stamp, 1'b0);
    end
    frames_sent++;
  endtask

  // drain outstanding results, then let a possible in-flight edge settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (readings_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input swhs_pkg::cfg_idx_t idx,
                           input logic [swhs_pkg::CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  initial begin
    logic [swhs_pkg::CFG_W-1:0] nthr, nlead;
    int                         seen0, items0, pick;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lead pulse across timer wrap, then repeated rises and repeated falls
    drive_edge(1'b1, 1'b1, 16'hFFF0, 1'b1);
    drive_edge(1'b0, 1'b0, 16'h0010, 1'b1);
    drive_edge(1'b0, 1'b1, 16'h0000, 1'b1);
    drive_edge(1'b0, 1'b1, 16'h0005, 1'b1);
    drive_edge(1'b0, 1'b0, 16'h0100, 1'b1);
    drive_edge(1'b0, 1'b0, 16'hFFFF, 1'b1);
    // start on a falling edge is measured against the last rise
    drive_edge(1'b1, 1'b0, 16'h0050, 1'b1);
    drive_edge(1'b0, 1'b1, 16'hFFFF, 1'b1);
    drive_edge(1'b0, 1'b0, 16'hFFFF, 1'b1);
    // widest lead pulse, so the pulse exactly at the threshold is skipped as a second lead, then a width just under it
    drive_edge(1'b1, 1'b1, 16'h0000, 1'b1);
    drive_edge(1'b0, 1'b0, 16'hFFFF, 1'b1);
    drive_edge(1'b0, 1'b1, 16'h1234, 1'b1);
    drive_edge(1'b0, 1'b0, 16'h1287, 1'b1);
    drive_edge(1'b0, 1'b1, 16'h2000, 1'b1);
    drive_edge(1'b0, 1'b0, 16'h2052, 1'b1);
    // lead pulse equal to the limit skips only one
    drive_edge(1'b1, 1'b1, 16'h8000, 1'b1);
    drive_edge(1'b0, 1'b0, 16'h9388, 1'b1);
    drive_edge(1'b0, 1'b1, 16'h9400, 1'b1);
    drive_edge(1'b0, 1'b0, 16'h9460, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          nthr  = swhs_pkg::THRESH_RESET;
          nlead = swhs_pkg::LEAD_RESET;
        end
        1: begin
          nthr  = '0;
          nlead = '0;
        end
        2: begin
          nthr  = '1;
          nlead = '1;
        end
        3: begin
          nthr  = 16'd1;
          nlead = 16'hFFFE;
        end
        4: begin
          nthr  = 16'($urandom);
          nlead = 16'($urandom);
        end
        default: begin
          nthr  = 16'($urandom_range(20, 200));
          nlead = 16'($urandom_range(50, 6000));
        end
      endcase
      wait_idle();
      write_reg(swhs_pkg::CFG_BIT_THRESHOLD, nthr);
      write_reg(swhs_pkg::CFG_LEAD_IN_LIMIT, nlead);
      cfg_wr_en <= 1'b0;
      thr  = nthr;
      lead = nlead;

      seen0  = readings_seen;
      items0 = edges_sent;
      while (edges_sent - items0 < ITEM_TARGET / PHASES ||
             readings_seen - seen0 < READINGS_PER_PHASE) begin
        calm <= ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 99);
        if (frames_sent < 4 || pick < 70)
          send_frame(make_frame(frames_sent < 4 ? frame_kind_t'(frames_sent) : FRAME_RANDOM),
                     swhs_pkg::FRAME_W, 1'b0, $urandom_range(0, 2));
        else if (pick < 85)
          send_frame(make_frame(FRAME_RANDOM), $urandom_range(20, swhs_pkg::FRAME_W), 1'b1, 0);
        else
          repeat ($urandom_range(1, 6))
            drive_edge($urandom_range(0, 3) == 0, 1'($urandom), 16'($urandom), 1'b1);
      end
    end

    calm <= 1'b0;
    wait_idle();
    if (mismatches == 0 && readings_due == 0)
      $display("single_wire_humidity_sensor_decoder_unit verification clean");
    else
      $display("single_wire_humidity_sensor_decoder_unit verification failed");
    $finish;
  end

endmodule
